FILE: hw/rtl/usb_transfer_descriptor_planner_top_defines.svh
// assertion macros shared by the planner modules
// each use needs clk and rst_n in scope
`ifndef USB_TRANSFER_DESCRIPTOR_PLANNER_TOP_DEFINES_SVH
`define USB_TRANSFER_DESCRIPTOR_PLANNER_TOP_DEFINES_SVH

// consequence in the same cycle
`define USBTDP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usbtdp assertion failed");

// consequence in the next cycle
`define USBTDP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usbtdp assertion failed");

`endif

FILE: hw/rtl/usbtdp_pkg.sv
package usbtdp_pkg;

    localparam int MAX_DESCRIPTORS = 64;
    localparam int TOGGLE_ENTRIES = 2048;

    localparam int IDX_W = $clog2(TOGGLE_ENTRIES);
    localparam int RAW_W = 11;
    localparam int ENT_W = RAW_W + 1;
    localparam int LIMIT_W = $clog2(MAX_DESCRIPTORS + 1);
    localparam int MPS_W = 10;
    localparam int LEN_W = 12;
    localparam int SLEN_W = 4;
    localparam int PROD_W = MPS_W + LIMIT_W;

    localparam logic [LIMIT_W-1:0] DATA_LIMIT = LIMIT_W'(MAX_DESCRIPTORS);
    localparam logic [LIMIT_W-1:0] CTRL_LIMIT = LIMIT_W'(MAX_DESCRIPTORS - 2);
    localparam logic [ENT_W-1:0] ENTRIES_EXT = ENT_W'(TOGGLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOGGLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        PID_SETUP = 2'd0,
        PID_OUT   = 2'd1,
        PID_IN    = 2'd2
    } pid_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_TOOLONG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        EMIT_NONE   = 3'd0,
        EMIT_SETUP  = 3'd1,
        EMIT_DATA   = 3'd2,
        EMIT_STATUS = 3'd3,
        EMIT_REPORT = 3'd4
    } emit_t;

    typedef struct packed {
        logic  clear_step;
        logic  capture;
        logic  reduce;
        logic  load_toggle;
        emit_t emit;
        logic  wr_toggle;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic idx_ready;
        logic is_ctrl;
        logic is_empty;
        logic too_long;
        logic len_zero;
        logic data_last;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: hw/rtl/usb_transfer_descriptor_planner_top.sv
// after reset the toggle store is swept to zero, one entry a cycle, with in_ready low;
// the result register comes up empty
// an item goes through capture, the index check (repeated for each table wrap when the
// store is smaller than the endpoint space), decide, and a store lookup for data transfers,
// then one descriptor a cycle while out_ready holds; no new item is taken before the
// last descriptor is issued, and the next item can be taken the cycle after it
module usb_transfer_descriptor_planner_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        direction_in,
    input  logic [11:0] transfer_length,
    input  logic [3:0]  setup_length,
    input  logic [9:0]  ep_packet_size,
    input  logic        slow_link,
    input  logic [6:0]  device_address,
    input  logic [3:0]  endpoint_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  packet_id,
    output logic [9:0]  packet_length,
    output logic [11:0] buffer_offset,
    output logic        data_toggle,
    output logic [6:0]  target_address,
    output logic [3:0]  target_endpoint,
    output logic        slow_device,
    output logic        last_with_ioc,
    output logic [1:0]  status
);

    import usbtdp_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t sts;

    usbtdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .dp_cmd   (dp_cmd)
    );

    usbtdp_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .sts             (sts),
        .cmd             (cmd),
        .direction_in    (direction_in),
        .transfer_length (transfer_length),
        .setup_length    (setup_length),
        .ep_packet_size  (ep_packet_size),
        .slow_link       (slow_link),
        .device_address  (device_address),
        .endpoint_number (endpoint_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .packet_id       (packet_id),
        .packet_length   (packet_length),
        .buffer_offset   (buffer_offset),
        .data_toggle     (data_toggle),
        .target_address  (target_address),
        .target_endpoint (target_endpoint),
        .slow_device     (slow_device),
        .last_with_ioc   (last_with_ioc),
        .status          (status)
    );

endmodule

FILE: hw/rtl/usbtdp_ram.sv
module usbtdp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/usbtdp_ctrl.sv
`include "usb_transfer_descriptor_planner_top_defines.svh"

module usbtdp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  usbtdp_pkg::dp_sts_t sts,
    output usbtdp_pkg::dp_cmd_t dp_cmd
);

    import usbtdp_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_LOOKUP = 9'b000010000,
        S_SETUP  = 9'b000100000,
        S_DATA   = 9'b001000000,
        S_STATUS = 9'b010000000,
        S_REPORT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        dp_cmd = '0;
        dp_cmd.emit = EMIT_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                dp_cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                dp_cmd.reduce = 1'b1;
                if (sts.idx_ready)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.is_empty || sts.too_long)
                begin
                    state_next = S_REPORT;
                end
                else if (sts.is_ctrl)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                dp_cmd.load_toggle = 1'b1;
                state_next = S_DATA;
            end
            S_SETUP:
            begin
                if (sts.out_free)
                begin
                    dp_cmd.emit = EMIT_SETUP;
                    state_next = sts.len_zero ? S_STATUS : S_DATA;
                end
            end
            S_DATA:
            begin
                if (sts.out_free)
                begin
                    dp_cmd.emit = EMIT_DATA;
                    if (sts.data_last)
                    begin
                        if (sts.is_ctrl)
                        begin
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            dp_cmd.wr_toggle = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_STATUS:
            begin
                if (sts.out_free)
                begin
                    dp_cmd.emit = EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (sts.out_free)
                begin
                    dp_cmd.emit = EMIT_REPORT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `USBTDP_ASSERT_NXT(a_accept_starts_check, in_valid && in_ready, state_reg == S_CHECK)
    `USBTDP_ASSERT_IMP(a_emit_needs_room, dp_cmd.emit != EMIT_NONE, sts.out_free)
    `USBTDP_ASSERT_IMP(a_writeback_data_only,
        dp_cmd.wr_toggle, sts.data_last && !sts.is_ctrl && dp_cmd.emit == EMIT_DATA)

endmodule

FILE: hw/rtl/usbtdp_datapath.sv
`include "usb_transfer_descriptor_planner_top_defines.svh"

module usbtdp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  usbtdp_pkg::dp_cmd_t dp_cmd,
    output usbtdp_pkg::dp_sts_t sts,
    input  logic                cmd,
    input  logic                direction_in,
    input  logic [11:0]         transfer_length,
    input  logic [3:0]          setup_length,
    input  logic [9:0]          ep_packet_size,
    input  logic                slow_link,
    input  logic [6:0]          device_address,
    input  logic [3:0]          endpoint_number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          packet_id,
    output logic [9:0]          packet_length,
    output logic [11:0]         buffer_offset,
    output logic                data_toggle,
    output logic [6:0]          target_address,
    output logic [3:0]          target_endpoint,
    output logic                slow_device,
    output logic                last_with_ioc,
    output logic [1:0]          status
);

    import usbtdp_pkg::*;

    // request
    logic               ctrl_reg;
    logic               dir_reg;
    logic               low_reg;
    logic [6:0]         addr_reg;
    logic [3:0]         ep_reg;
    logic [SLEN_W-1:0]  slen_reg;
    logic [MPS_W-1:0]   mps_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   remain_reg;
    logic [LEN_W-1:0]   off_reg;
    logic               tog_reg;
    logic [RAW_W-1:0]   idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [IDX_W-1:0]   clr_reg;

    // result register
    logic               out_valid_reg;
    pid_t               pid_reg;
    logic [MPS_W-1:0]   plen_reg;
    logic [LEN_W-1:0]   boff_reg;
    logic               otog_reg;
    logic [6:0]         oaddr_reg;
    logic [3:0]         oep_reg;
    logic               olow_reg;
    logic               ioc_reg;
    status_t            status_reg;

    logic [LIMIT_W-1:0] limit;
    logic [MPS_W-1:0]   plen;
    logic               data_last;
    logic               idx_high;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic               ram_wr_data;
    logic               ram_rd_data;
    logic               load;

    assign limit = ctrl_reg ? CTRL_LIMIT : DATA_LIMIT;
    assign data_last = remain_reg <= LEN_W'(mps_reg);
    assign plen = data_last ? remain_reg[MPS_W-1:0] : mps_reg;
    assign idx_high = {1'b0, idx_reg} >= ENTRIES_EXT;
    assign load = dp_cmd.emit != EMIT_NONE;

    assign sts.clear_done = clr_reg == LAST_IDX;
    assign sts.idx_ready = !idx_high;
    assign sts.is_ctrl = ctrl_reg;
    assign sts.is_empty = !ctrl_reg && (len_reg == '0);
    assign sts.too_long = PROD_W'(len_reg) > prod_reg;
    assign sts.len_zero = len_reg == '0;
    assign sts.data_last = data_last;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign ram_wr_en = dp_cmd.clear_step || dp_cmd.wr_toggle;
    assign ram_wr_addr = dp_cmd.clear_step ? clr_reg : idx_reg[IDX_W-1:0];
    assign ram_wr_data = dp_cmd.clear_step ? 1'b0 : ~tog_reg;

    usbtdp_ram #(
        .WIDTH (1),
        .DEPTH (TOGGLE_ENTRIES)
    ) u_toggle_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (dp_cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mps_reg) * PROD_W'(limit);
        if (dp_cmd.capture)
        begin
            ctrl_reg <= cmd;
            dir_reg <= direction_in;
            low_reg <= slow_link;
            addr_reg <= device_address;
            ep_reg <= endpoint_number;
            slen_reg <= setup_length;
            mps_reg <= (ep_packet_size == '0) ? MPS_W'(1) : ep_packet_size;
            len_reg <= transfer_length;
            remain_reg <= transfer_length;
            off_reg <= '0;
            tog_reg <= 1'b0;
            idx_reg <= {device_address, endpoint_number};
        end
        else
        begin
            if (dp_cmd.reduce && idx_high)
            begin
                idx_reg <= idx_reg - ENTRIES_EXT[RAW_W-1:0];
            end
            if (dp_cmd.load_toggle)
            begin
                tog_reg <= ram_rd_data;
            end
            if (dp_cmd.emit == EMIT_SETUP)
            begin
                tog_reg <= 1'b1;
            end
            if (dp_cmd.emit == EMIT_DATA)
            begin
                tog_reg <= ~tog_reg;
                off_reg <= off_reg + LEN_W'(plen);
                remain_reg <= remain_reg - LEN_W'(plen);
            end
        end

        if (load)
        begin
            oaddr_reg <= addr_reg;
            oep_reg <= ep_reg;
            olow_reg <= low_reg;
        end
        unique case (dp_cmd.emit)
            EMIT_NONE:
            begin
            end
            EMIT_SETUP:
            begin
                pid_reg <= PID_SETUP;
                plen_reg <= MPS_W'(slen_reg);
                boff_reg <= '0;
                otog_reg <= 1'b0;
                ioc_reg <= 1'b0;
                status_reg <= ST_OK;
            end
            EMIT_DATA:
            begin
                pid_reg <= dir_reg ? PID_IN : PID_OUT;
                plen_reg <= plen;
                boff_reg <= off_reg;
                otog_reg <= tog_reg;
                ioc_reg <= !ctrl_reg && data_last;
                status_reg <= ST_OK;
            end
            EMIT_STATUS:
            begin
                pid_reg <= dir_reg ? PID_OUT : PID_IN;
                plen_reg <= '0;
                boff_reg <= '0;
                otog_reg <= 1'b1;
                ioc_reg <= 1'b1;
                status_reg <= ST_OK;
            end
            EMIT_REPORT:
            begin
                pid_reg <= PID_SETUP;
                plen_reg <= '0;
                boff_reg <= '0;
                otog_reg <= 1'b0;
                ioc_reg <= 1'b0;
                status_reg <= sts.is_empty ? ST_EMPTY : ST_TOOLONG;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign packet_id = pid_reg;
    assign packet_length = plen_reg;
    assign buffer_offset = boff_reg;
    assign data_toggle = otog_reg;
    assign target_address = oaddr_reg;
    assign target_endpoint = oep_reg;
    assign slow_device = olow_reg;
    assign last_with_ioc = ioc_reg;
    assign status = status_reg;

    `USBTDP_ASSERT_NXT(a_data_leaves_remainder,
        dp_cmd.emit == EMIT_DATA && !data_last, remain_reg != '0)
    `USBTDP_ASSERT_NXT(a_toggle_alternates,
        dp_cmd.emit == EMIT_DATA, tog_reg != $past(tog_reg))
    `USBTDP_ASSERT_NXT(a_result_held,
        out_valid_reg && !out_ready, out_valid_reg && $stable(plen_reg) && $stable(boff_reg))

endmodule
